### rtl/core/lae_pkg.sv
// Shared constants, request codes and control structs for the Life automaton engine.
`timescale 1ns / 1ps
`default_nettype none

package lae_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);
	localparam int NCOL_W   = $clog2(MAX_COLS + 1);
	localparam int CFG_W    = 7;
	localparam int GEN_W    = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_STEP  = 2'd1,
		REQ_READ  = 2'd2
	} req_code_t;

	typedef struct packed {
		logic latch_req;
		logic rd_req;
		logic step_start;
		logic load_mid;
		logic calc;
		logic cell_write;
		logic out_read;
		logic out_step;
	} cmd_t;

	typedef struct packed {
		logic rows_zero;
		logic last_row;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/life_automaton_engine.sv
// Top level of the Life automaton engine with its size registers and APB port.
// A write passes through the write state; a read waits until the result register is free.
// A step sweeps the board one row per cycle through the single read and write port of the
// board memory after the fill state; its result waits in the done state until the result
// register is free. The sweep is skipped when no row is active.
// A new request is taken whenever the controller is idle, also while a result waits.
// Reset clears the per-row valid bits, so the board reads as all dead at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_engine
	import lae_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         req_type,
	input  logic [5:0]         cell_row,
	input  logic [5:0]         cell_col,
	input  logic               cell_alive,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               result_kind,
	output logic               alive_out,
	output logic [GEN_W-1:0]   generation
);

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] col_count_q;
	logic             cfg_write;
	cmd_t             cmd;
	sts_t             sts;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CFG_RESET;
			col_count_q <= CFG_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_ROW_COUNT) begin
				row_count_q <= pwdata[CFG_W-1:0];
			end else begin
				col_count_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_COL_COUNT) ? PDATA_W'(col_count_q) : PDATA_W'(row_count_q);

	lae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_type),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lae_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_alive (cell_alive),
		.row_count  (row_count_q),
		.col_count  (col_count_q),
		.rsp_ready  (rsp_ready),
		.rsp_valid  (rsp_valid),
		.result_kind(result_kind),
		.alive_out  (alive_out),
		.generation (generation)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !(cmd.out_read || cmd.out_step))
		else $error("result register loaded while a result is still pending");

	a_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !(cmd.calc || cmd.cell_write || cmd.load_mid))
		else $error("request port ready while a command is in progress");

	a_write_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_type == REQ_WRITE) |=> cmd.cell_write)
		else $error("cell write did not follow a write transfer");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_step |=> (rsp_valid && result_kind && !alive_out))
		else $error("step result not presented correctly");

endmodule

`default_nettype wire

### rtl/core/lae_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lae_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/core/lae_ctrl.sv
// Controller state machine that sequences cell accesses and the generation sweep.
`timescale 1ns / 1ps
`default_nettype none

module lae_ctrl
	import lae_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	output logic       req_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WRITE = 6'b000010,
		ST_READ  = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_CALC  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					case (req_code_t'(req_type))
						REQ_WRITE: begin
							cmd.rd_req = 1'b1;
							state_d    = ST_WRITE;
						end
						REQ_READ: begin
							cmd.rd_req = 1'b1;
							state_d    = ST_READ;
						end
						REQ_STEP: begin
							cmd.step_start = 1'b1;
							state_d        = sts.rows_zero ? ST_DONE : ST_FILL;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_WRITE: begin
				cmd.cell_write = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_READ: begin
				if (sts.out_free) begin
					cmd.out_read = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FILL: begin
				cmd.load_mid = 1'b1;
				state_d      = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				if (sts.last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_step = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lae_dp.sv
// Datapath with the board memory, row window, Life rule logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module lae_dp
	import lae_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [5:0]       cell_row,
	input  logic [5:0]       cell_col,
	input  logic             cell_alive,
	input  logic [CFG_W-1:0] row_count,
	input  logic [CFG_W-1:0] col_count,
	input  logic             rsp_ready,
	output logic             rsp_valid,
	output logic             result_kind,
	output logic             alive_out,
	output logic [GEN_W-1:0] generation
);

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	logic [CNT_W-1:0]    nr;
	logic [NCOL_W-1:0]   ncol;
	logic [MAX_COLS-1:0] cmask;

	logic [5:0]          req_row_q;
	logic [5:0]          req_col_q;
	logic                req_alive_q;
	logic [MAX_ROWS-1:0] vld_q;
	logic                rvld_q;
	logic [ROW_W-1:0]    idx_q;
	logic [MAX_COLS-1:0] up_q;
	logic [MAX_COLS-1:0] mid_q;
	logic [GEN_W-1:0]    gen_q;

	logic                rsp_valid_q;
	logic                result_kind_q;
	logic                alive_q;
	logic [GEN_W-1:0]    gen_out_q;

	logic                ram_re;
	logic [ROW_W-1:0]    ram_raddr;
	logic [MAX_COLS-1:0] ram_rdata;
	logic                ram_we;
	logic [ROW_W-1:0]    ram_waddr;
	logic [MAX_COLS-1:0] ram_wdata;

	logic [MAX_COLS-1:0] row_data;
	logic [MAX_COLS-1:0] dn_row;
	logic [MAX_COLS-1:0] next_row;
	logic [MAX_COLS-1:0] cell_row_data;
	logic [CNT_W-1:0]    idx_next;
	logic                has_dn;
	logic                in_area;

	always_comb begin
		nr   = (int'(row_count) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : CNT_W'(row_count);
		ncol = (int'(col_count) > MAX_COLS) ? NCOL_W'(MAX_COLS) : NCOL_W'(col_count);
		for (int i = 0; i < MAX_COLS; i++) begin
			cmask[i] = (NCOL_W'(i) < ncol);
		end
	end

	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
	assign has_dn   = (idx_next < nr);
	assign in_area  = (CNT_W'(req_row_q) < nr) && (NCOL_W'(req_col_q) < ncol);
	assign row_data = ram_rdata & {MAX_COLS{rvld_q}} & cmask;
	assign dn_row   = has_dn ? row_data : '0;

	assign sts.rows_zero = (nr == '0);
	assign sts.last_row  = (idx_next == nr);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		logic [MAX_COLS+1:0] up_p;
		logic [MAX_COLS+1:0] mid_p;
		logic [MAX_COLS+1:0] dn_p;
		logic [3:0]          n;
		up_p  = {1'b0, up_q, 1'b0};
		mid_p = {1'b0, mid_q, 1'b0};
		dn_p  = {1'b0, dn_row, 1'b0};
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) + 4'(mid_p[c]) + 4'(mid_p[c+2])
				+ 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
			next_row[c] = cmask[c] &&
				((n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && mid_q[c]));
		end
	end

	always_comb begin
		cell_row_data = ram_rdata & {MAX_COLS{rvld_q}};
		cell_row_data[COL_W'(req_col_q)] = req_alive_q;
	end

	always_comb begin
		ram_re    = cmd.rd_req || cmd.step_start || cmd.load_mid || cmd.calc;
		ram_raddr = '0;
		if (cmd.rd_req) begin
			ram_raddr = ROW_W'(cell_row);
		end else if (cmd.load_mid) begin
			ram_raddr = ROW_W'(1);
		end else if (cmd.calc) begin
			ram_raddr = ROW_W'(idx_next + CNT_W'(1));
		end
		ram_we    = cmd.calc || (cmd.cell_write && in_area);
		ram_waddr = cmd.calc ? idx_q : ROW_W'(req_row_q);
		ram_wdata = cmd.calc ? next_row : cell_row_data;
	end

	lae_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_board (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_row_q   <= cell_row;
			req_col_q   <= cell_col;
			req_alive_q <= cell_alive;
		end
		if (ram_re) begin
			rvld_q <= vld_q[ram_raddr];
		end
		if (cmd.load_mid) begin
			idx_q <= '0;
		end else if (cmd.calc) begin
			idx_q <= ROW_W'(idx_next);
		end
		if (cmd.step_start) begin
			up_q <= '0;
		end else if (cmd.load_mid) begin
			mid_q <= row_data;
		end else if (cmd.calc) begin
			up_q  <= mid_q;
			mid_q <= dn_row;
		end
		if (cmd.out_read) begin
			result_kind_q <= 1'b0;
			alive_q       <= in_area && rvld_q && ram_rdata[COL_W'(req_col_q)];
			gen_out_q     <= gen_q;
		end else if (cmd.out_step) begin
			result_kind_q <= 1'b1;
			alive_q       <= 1'b0;
			gen_out_q     <= gen_q + GEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			gen_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.step_start) begin
				for (int i = 0; i < MAX_ROWS; i++) begin
					if (CNT_W'(i) >= nr) begin
						vld_q[i] <= 1'b0;
					end
				end
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (cmd.out_step) begin
				gen_q <= gen_q + GEN_W'(1);
			end
			if (cmd.out_read || cmd.out_step) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_kind = result_kind_q;
	assign alive_out   = alive_q;
	assign generation  = gen_out_q;

endmodule

`default_nettype wire
